// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/nhrgb_pkg.sv =====
package nhrgb_pkg;

    // crc-16 reflected, x.25 style
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // 0.6 in unsigned 0.16, rounded
    localparam logic [15:0] GRAY_LEVEL = 16'd39322;

    // rounding: r = floor((256 * num + 1912) / 3825), same as the /979200 form;
    // the divide by 3825 is a multiply by ceil(2^40 / 3825) and a 40-bit shift,
    // exact for every dividend below 2^28
    localparam logic [28:0] RECIP_MULT = 29'd287454021;
    localparam logic [10:0] ROUND_BIAS = 11'd1912;
    localparam logic [9:0]  HUE_SPAN   = 10'd765;

    // configuration register indexes
    localparam logic CFG_COLORIZE_ENABLE = 1'b0;
    localparam logic CFG_HUE_OFFSET      = 1'b1;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_LOAD,
        U_DIV,
        U_DONE
    } unit_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_BUSY,
        ST_HOLD
    } top_state_t;

    typedef struct packed {
        logic  start;
        chan_t chan;
    } unit_ctl_t;

    typedef struct packed {
        logic        done;
        logic [15:0] level;
    } unit_sts_t;

endpackage

// ===== hw/rtl/name_hash_to_rgb_color.sv =====
// Name-to-color block: name bytes stream in one per transaction on the s_ side
// (byte in s_tdata, s_tuser set when the byte is real, s_tlast on the final one)
// and a reflected crc-16 (poly 0x8408, start 0xffff) runs over them. The final
// transaction inverts and byte-swaps the crc; its high byte plus hue_offset is the
// hue, its low byte sets saturation 0.5 + s/512, lightness is fixed at 0.6, and one
// result carrying red, green, blue (unsigned 0.16, rounded) and the crc leaves on
// the m_ side. A final transaction with s_tuser low ends an empty name (crc 0).
// With colorize_enable low the color is a gray of 0.6. A non-final byte is taken
// without leaving idle. With colorizing on, a final byte is worked on by the
// single shared channel unit: after the accept, per channel a launch step, a
// multiply step, a load step, a reciprocal-multiply step and a done step, for
// three channels, then a move into the output register once it is free; with
// colorizing off the accept goes straight to that move. s_tready is low while a final byte is
// being worked on and while a finished result waits for the output register.
// The output register lets the next name stream in while a result is still
// waiting on m_tready. Configuration is written through cfg_we/cfg_addr/cfg_wdata
// by the user only while the block is idle; the block does not enforce this.
module name_hash_to_rgb_color (
    input  logic        clk,
    input  logic        rst_n,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // name_byte
    input  logic        s_tuser,    // byte_present
    input  logic        s_tlast,    // last_byte

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // red, green, blue, final_crc (lowest first)

    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    nhrgb_pkg::top_state_t state_reg, state_next;
    nhrgb_pkg::chan_t      chan_reg, chan_next;

    logic        colorize_reg;
    logic [7:0]  hue_off_reg;

    logic [15:0] crc_out_reg, crc_out_next;
    logic [7:0]  hue_reg, hue_next;
    logic [7:0]  sat_reg, sat_next;
    logic [15:0] red_reg, red_next;
    logic [15:0] green_reg, green_next;
    logic [15:0] blue_reg, blue_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    logic        in_accept;
    logic [15:0] fin;

    nhrgb_pkg::unit_ctl_t unit_ctl;
    nhrgb_pkg::unit_sts_t unit_sts;

    assign s_tready  = (state_reg == nhrgb_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // running crc; fin already includes the byte of this transaction
    nhrgb_crc u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .present (s_tuser),
        .last    (s_tlast),
        .data    (s_tdata),
        .fin     (fin)
    );

    // shared channel unit: ramp multiply then divide-and-round
    nhrgb_unit u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (unit_ctl),
        .hue_byte (hue_reg),
        .sat_byte (sat_reg),
        .sts      (unit_sts)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colorize_reg <= 1'b1;
            hue_off_reg  <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                nhrgb_pkg::CFG_COLORIZE_ENABLE: colorize_reg <= cfg_wdata[0];
                nhrgb_pkg::CFG_HUE_OFFSET:      hue_off_reg  <= cfg_wdata;
                default:                        hue_off_reg  <= hue_off_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        crc_out_next   = crc_out_reg;
        hue_next       = hue_reg;
        sat_next       = sat_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unit_ctl.start = 1'b0;
        unit_ctl.chan  = chan_reg;

        unique case (state_reg)
            nhrgb_pkg::ST_IDLE:
            begin
                if (in_accept && s_tlast)
                begin
                    crc_out_next = fin;
                    hue_next     = 8'(fin[15:8] + hue_off_reg);
                    sat_next     = fin[7:0];
                    chan_next    = nhrgb_pkg::CH_RED;
                    if (colorize_reg)
                        state_next = nhrgb_pkg::ST_LAUNCH;
                    else
                    begin
                        red_next   = nhrgb_pkg::GRAY_LEVEL;
                        green_next = nhrgb_pkg::GRAY_LEVEL;
                        blue_next  = nhrgb_pkg::GRAY_LEVEL;
                        state_next = nhrgb_pkg::ST_HOLD;
                    end
                end
            end
            nhrgb_pkg::ST_LAUNCH:
            begin
                unit_ctl.start = 1'b1;
                state_next     = nhrgb_pkg::ST_BUSY;
            end
            nhrgb_pkg::ST_BUSY:
            begin
                if (unit_sts.done)
                begin
                    unique case (chan_reg)
                        nhrgb_pkg::CH_RED:
                        begin
                            red_next   = unit_sts.level;
                            chan_next  = nhrgb_pkg::CH_GREEN;
                            state_next = nhrgb_pkg::ST_LAUNCH;
                        end
                        nhrgb_pkg::CH_GREEN:
                        begin
                            green_next = unit_sts.level;
                            chan_next  = nhrgb_pkg::CH_BLUE;
                            state_next = nhrgb_pkg::ST_LAUNCH;
                        end
                        nhrgb_pkg::CH_BLUE:
                        begin
                            blue_next  = unit_sts.level;
                            state_next = nhrgb_pkg::ST_HOLD;
                        end
                        default:
                            state_next = nhrgb_pkg::ST_IDLE;
                    endcase
                end
            end
            nhrgb_pkg::ST_HOLD:
            begin
                // move into the output register once it is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {crc_out_reg, blue_reg, green_reg, red_reg};
                    state_next     = nhrgb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = nhrgb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nhrgb_pkg::ST_IDLE;
            chan_reg      <= nhrgb_pkg::CH_RED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_out_reg  <= crc_out_next;
        hue_reg      <= hue_next;
        sat_reg      <= sat_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hw/rtl/nhrgb_crc.sv =====
module nhrgb_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        present,
    input  logic        last,
    input  logic [7:0]  data,
    output logic [15:0] fin
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] upd;
    logic [15:0] inv;

    // one byte, lsb first, eight narrow shift/xor steps
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d_in);
        logic [15:0] c;
        logic [7:0]  d;
        c = c_in;
        d = d_in;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ d[0])
                c = (c >> 1) ^ nhrgb_pkg::CRC_POLY;
            else
                c = c >> 1;
            d = d >> 1;
        end
        return c;
    endfunction

    assign upd = present ? crc_byte(crc_reg, data) : crc_reg;
    assign inv = ~upd;
    assign fin = {inv[7:0], inv[15:8]};

    always_comb
    begin
        crc_next = crc_reg;
        if (accept)
            crc_next = last ? nhrgb_pkg::CRC_INIT : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= nhrgb_pkg::CRC_INIT;
        else
            crc_reg <= crc_next;
    end

endmodule

// ===== hw/rtl/nhrgb_unit.sv =====
module nhrgb_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nhrgb_pkg::unit_ctl_t ctl,
    input  logic [7:0]           hue_byte,
    input  logic [7:0]           sat_byte,
    output nhrgb_pkg::unit_sts_t sts
);

    nhrgb_pkg::unit_state_t state_reg, state_next;

    logic [19:0] prod_reg, prod_next;
    logic [19:0] base_reg, base_next;
    logic [27:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;

    logic [9:0]  h3;
    logic [10:0] t_wide;
    logic [9:0]  t;
    logic [9:0]  pv;
    logic [10:0] qv;
    logic [9:0]  diff;
    logic [6:0]  m;
    logic [9:0]  m6;
    logic [10:0] sel;
    logic [19:0] num;
    logic [20:0] sum_wide;
    logic [55:0] recip_prod;

    // position within the hue circle, in units of 1/765
    always_comb
    begin
        h3 = 10'({2'b00, hue_byte} + {1'b0, hue_byte, 1'b0});
        t_wide = {1'b0, h3};
        unique case (ctl.chan)
            nhrgb_pkg::CH_RED:
            begin
                t_wide = 11'({1'b0, h3} + 11'd255);
                if (t_wide > {1'b0, nhrgb_pkg::HUE_SPAN})
                    t_wide = t_wide - {1'b0, nhrgb_pkg::HUE_SPAN};
            end
            nhrgb_pkg::CH_GREEN:
                t_wide = {1'b0, h3};
            nhrgb_pkg::CH_BLUE:
            begin
                if (h3 < 10'd255)
                    t_wide = 11'({1'b0, h3} + 11'd510);
                else
                    t_wide = 11'({1'b0, h3} - 11'd255);
            end
            default:
                t_wide = {1'b0, h3};
        endcase
        t = t_wide[9:0];
    end

    assign pv   = 10'(10'd512 - {2'b00, sat_byte});
    assign qv   = 11'(11'd1024 + {3'b000, sat_byte});
    assign diff = 10'(10'd512 + {1'b0, sat_byte, 1'b0});

    // rising ramp, plateau at q, falling ramp, floor at p
    always_comb
    begin
        m   = 7'd0;
        sel = {1'b0, pv};
        if (t < 10'd128)
            m = t[6:0];
        else if (t < 10'd383)
            sel = qv;
        else if (t < 10'd510)
            m = 7'(10'd510 - t);
        // 6 * m as 4 * m + 2 * m
        m6 = 10'({3'b000, m, 2'b00} + {4'b0000, m, 1'b0});
    end

    assign sum_wide   = {1'b0, base_reg} + {1'b0, prod_reg};
    assign num        = sum_wide[19:0];
    assign recip_prod = {28'b0, rem_reg} * {27'b0, nhrgb_pkg::RECIP_MULT};

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        base_next  = base_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sts.done   = 1'b0;
        sts.level  = quo_reg;
        unique case (state_reg)
            nhrgb_pkg::U_IDLE:
            begin
                if (ctl.start)
                    state_next = nhrgb_pkg::U_MUL;
            end
            nhrgb_pkg::U_MUL:
            begin
                prod_next  = {10'b0, diff} * {10'b0, m6};
                // times 765 = 1024 - 256 - 2 - 1
                base_next  = 20'({sel, 10'b0} - {2'b00, sel, 8'b0} - {9'b0, sel, 1'b0}
                                 - {10'b0, sel});
                state_next = nhrgb_pkg::U_LOAD;
            end
            nhrgb_pkg::U_LOAD:
            begin
                rem_next   = {num, 8'b0} + {17'b0, nhrgb_pkg::ROUND_BIAS};
                state_next = nhrgb_pkg::U_DIV;
            end
            nhrgb_pkg::U_DIV:
            begin
                // divide by 3825 through the reciprocal, quotient fits 16 bits
                quo_next   = recip_prod[55:40];
                state_next = nhrgb_pkg::U_DONE;
            end
            nhrgb_pkg::U_DONE:
            begin
                sts.done   = 1'b1;
                state_next = nhrgb_pkg::U_IDLE;
            end
            default:
                state_next = nhrgb_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nhrgb_pkg::U_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        base_reg <= base_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

endmodule

// ===== hw/rtl/nhrgb_checker.sv =====
`include "assert_macros.svh"

module nhrgb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata
);

    logic in_acc;

    assign in_acc = s_tvalid && s_tready;

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a final byte always starts a busy phase
    `ASSERT_NEXT(a_last_busy, clk, rst_n, in_acc && s_tlast, !s_tready)
    // a non-final byte never stalls the input
    `ASSERT_NEXT(a_byte_fast, clk, rst_n, in_acc && !s_tlast, s_tready)
    // a new result only appears out of a busy phase
    `ASSERT_IMPLIES(a_rise_busy, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind name_hash_to_rgb_color nhrgb_checker u_nhrgb_checker (.*);
